/* sv/fmad_pkg.sv */
package fmad_pkg;

	localparam int RATE_W = 27;
	localparam int CNT_W = 16;
	localparam int TOL_W = 10;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int BIN_STEP = 10;
	localparam logic [TOL_W-1:0] MILLI = 10'd1000;

	localparam logic [RATE_W-1:0] BASE_RESET = 27'd40000;
	localparam logic [CNT_W-1:0] ACT_RESET = 16'd200;
	localparam logic [TOL_W-1:0] TOL_RESET = 10'd25;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_BASE = 2'd0;
	localparam logic [1:0] REG_ACT = 2'd1;
	localparam logic [1:0] REG_TOL = 2'd2;

	typedef struct packed {
		logic in_window;
		logic active;
		logic [RATE_W-1:0] mode_rate;
		logic [CNT_W-1:0] peak_count;
		logic suspicious;
	} res_t;

endpackage

/* sv/fmad_ram.sv */
module fmad_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// a read at the address being written returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/flow_mode_anomaly_detector.sv */
// an accepted sample beat passes stages 0 to 6 and then the result queue, from which its result is offered
// throughput: one sample per cycle while in_stall is low; the histogram ram is read in stage 2 and
// written back in stage 3, with the last write forwarded to the next update
// an 8-entry result queue holds finished beats; input stalls when 8 are outstanding
// reset: async, active low; then a sweep clears every histogram bin, input stalled
module flow_mode_anomaly_detector #(
	parameter int BINS = 1024
) (
	input  logic clk,
	input  logic arst_n,

	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [fmad_pkg::PADDR_W-1:0] paddr,
	input  logic [fmad_pkg::PDATA_W-1:0] pwdata,
	output logic [fmad_pkg::PDATA_W-1:0] prdata,
	output logic pready,

	input  logic in_valid,
	output logic in_stall,
	input  logic [fmad_pkg::RATE_W-1:0] rate_sample,

	output logic out_valid,
	input  logic out_stall,
	output logic in_window,
	output logic active,
	output logic [fmad_pkg::RATE_W-1:0] mode_rate,
	output logic [fmad_pkg::CNT_W-1:0] peak_count,
	output logic suspicious
);

	localparam int RW = fmad_pkg::RATE_W;
	localparam int CW = fmad_pkg::CNT_W;
	localparam int TW = fmad_pkg::TOL_W;
	localparam int BIN_W = $clog2(BINS);
	localparam int WIN = fmad_pkg::BIN_STEP * BINS;
	localparam int DIFF_W = $clog2(WIN);
	localparam int SH = DIFF_W + 4;
	localparam int PW = 2 * DIFF_W + 1;
	localparam logic [DIFF_W:0] RECIP = (DIFF_W+1)'(((longint'(1) << SH) + 9) / 10);
	localparam logic [RW-1:0] WIN_LIM = RW'(WIN);
	localparam int MW = RW + TW + 1;
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW = $clog2(OQ_DEPTH);

	// configuration
	logic [RW-1:0] base_q;
	logic [CW-1:0] act_q;
	logic [TW-1:0] tol_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= fmad_pkg::BASE_RESET;
			act_q <= fmad_pkg::ACT_RESET;
			tol_q <= fmad_pkg::TOL_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				fmad_pkg::REG_BASE: base_q <= pwdata[RW-1:0];
				fmad_pkg::REG_ACT: act_q <= pwdata[CW-1:0];
				fmad_pkg::REG_TOL: tol_q <= pwdata[TW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			fmad_pkg::REG_BASE: prdata = fmad_pkg::PDATA_W'(base_q);
			fmad_pkg::REG_ACT: prdata = fmad_pkg::PDATA_W'(act_q);
			fmad_pkg::REG_TOL: prdata = fmad_pkg::PDATA_W'(tol_q);
			default: prdata = '0;
		endcase
	end

	// histogram clear sweep after reset
	logic clr_q;
	logic [BIN_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == BIN_W'(BINS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// outstanding beats and input handshake
	logic [OQ_AW:0] pend_q;
	logic in_acc;
	logic out_acc;

	assign in_stall = clr_q || (pend_q == (OQ_AW+1)'(OQ_DEPTH));
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + (OQ_AW+1)'(in_acc) - (OQ_AW+1)'(out_acc);
		end
	end

	// stage 0: offset from base and window check
	logic [RW-1:0] diff;
	logic win_s0;

	assign diff = rate_sample - base_q;
	assign win_s0 = (rate_sample > base_q) && (diff < WIN_LIM);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic win_s1, win_s2, win_s3, win_s4, win_s5, win_s6;
	logic [RW-1:0] sample_s1, sample_s2, sample_s3, sample_s4, sample_s5;
	logic [DIFF_W-1:0] diff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= rate_sample;
		win_s1 <= win_s0;
		diff_s1 <= diff[DIFF_W-1:0];
	end

	// stage 1: bin = offset / 10 by reciprocal multiply
	logic [PW-1:0] quot_prod;
	logic [BIN_W-1:0] bin_s2, bin_s3;

	assign quot_prod = PW'(diff_s1) * PW'(RECIP);

	always_ff @(posedge clk) begin
		sample_s2 <= sample_s1;
		win_s2 <= win_s1;
		bin_s2 <= quot_prod[SH +: BIN_W];
	end

	// stage 2: counter read
	logic [CW-1:0] ram_rdata;
	logic ram_we;
	logic [BIN_W-1:0] ram_waddr;
	logic [CW-1:0] ram_wdata;

	always_ff @(posedge clk) begin
		sample_s3 <= sample_s2;
		win_s3 <= win_s2;
		bin_s3 <= bin_s2;
	end

	// stage 3: increment, write back, peak tracking
	logic wb_v_q;
	logic [BIN_W-1:0] wb_bin_q;
	logic [CW-1:0] wb_cnt_q;
	logic [CW-1:0] old_cnt;
	logic [CW-1:0] inc_cnt;
	logic we_s3;
	logic [CW-1:0] peak_q, peak_nxt;
	logic [BIN_W-1:0] mode_q, mode_nxt;

	// the write of the previous beat landed as this beat's read was issued
	assign old_cnt = (wb_v_q && (wb_bin_q == bin_s3)) ? wb_cnt_q : ram_rdata;
	assign inc_cnt = (old_cnt == fmad_pkg::CNT_MAX) ? old_cnt : old_cnt + 1'b1;
	assign we_s3 = v_s3 && win_s3;

	always_comb begin
		peak_nxt = peak_q;
		mode_nxt = mode_q;
		if (we_s3 && (inc_cnt > peak_q)) begin
			peak_nxt = inc_cnt;
			mode_nxt = bin_s3;
		end
	end

	assign ram_we = clr_q || we_s3;
	assign ram_waddr = clr_q ? clr_addr_q : bin_s3;
	assign ram_wdata = clr_q ? '0 : inc_cnt;

	fmad_ram #(
		.WIDTH(CW),
		.DEPTH(BINS)
	) u_hist (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(v_s2 && win_s2),
		.raddr(bin_s2),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_v_q <= 1'b0;
			peak_q <= '0;
			mode_q <= '0;
		end else begin
			wb_v_q <= we_s3;
			peak_q <= peak_nxt;
			mode_q <= mode_nxt;
		end
	end

	logic [CW-1:0] peak_s4, peak_s5, peak_s6;
	logic [BIN_W-1:0] mode_s4;

	always_ff @(posedge clk) begin
		wb_bin_q <= bin_s3;
		wb_cnt_q <= inc_cnt;
		sample_s4 <= sample_s3;
		win_s4 <= win_s3;
		peak_s4 <= peak_nxt;
		mode_s4 <= mode_nxt;
	end

	// stage 4: mode rate with saturation, activation
	logic [RW:0] mode_sum;
	logic [RW-1:0] mode_sat;
	logic act_s4;
	logic act_s5, act_s6;
	logic [RW-1:0] mode_s5, mode_s6;

	assign mode_sum = {1'b0, base_q} + (RW+1)'({mode_s4, 3'b000}) + (RW+1)'({mode_s4, 1'b0});
	assign mode_sat = mode_sum[RW] ? {RW{1'b1}} : mode_sum[RW-1:0];
	assign act_s4 = peak_s4 > act_q;

	always_ff @(posedge clk) begin
		sample_s5 <= sample_s4;
		win_s5 <= win_s4;
		peak_s5 <= peak_s4;
		act_s5 <= act_s4;
		mode_s5 <= act_s4 ? mode_sat : '0;
	end

	// stage 5: sample*1000 against mode*(1000+tol)
	logic [MW-1:0] lhs_s6, rhs_s6;
	logic [TW:0] scale;

	assign scale = (TW+1)'(fmad_pkg::MILLI) + (TW+1)'(tol_q);

	always_ff @(posedge clk) begin
		win_s6 <= win_s5;
		peak_s6 <= peak_s5;
		act_s6 <= act_s5;
		mode_s6 <= mode_s5;
		lhs_s6 <= MW'(sample_s5) * MW'(fmad_pkg::MILLI);
		rhs_s6 <= MW'(mode_s5) * MW'(scale);
	end

	// stage 6: compare and queue the result
	fmad_pkg::res_t res_s6;
	fmad_pkg::res_t oq_q [OQ_DEPTH];
	logic [OQ_AW:0] oq_wp_q, oq_rp_q;
	fmad_pkg::res_t head;

	always_comb begin
		res_s6.in_window = win_s6;
		res_s6.active = act_s6;
		res_s6.mode_rate = mode_s6;
		res_s6.peak_count = peak_s6;
		res_s6.suspicious = act_s6 && (lhs_s6 > rhs_s6);
	end

	always_ff @(posedge clk) begin
		if (v_s6) begin
			oq_q[oq_wp_q[OQ_AW-1:0]] <= res_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q <= '0;
			oq_rp_q <= '0;
		end else begin
			if (v_s6) begin
				oq_wp_q <= oq_wp_q + 1'b1;
			end
			if (out_acc) begin
				oq_rp_q <= oq_rp_q + 1'b1;
			end
		end
	end

	assign head = oq_q[oq_rp_q[OQ_AW-1:0]];
	assign out_valid = oq_wp_q != oq_rp_q;
	assign in_window = head.in_window;
	assign active = head.active;
	assign mode_rate = head.mode_rate;
	assign peak_count = head.peak_count;
	assign suspicious = head.suspicious;

endmodule

/* sv/fmad_checker.sv */
module fmad_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic in_window,
	input logic active,
	input logic [fmad_pkg::RATE_W-1:0] mode_rate,
	input logic [fmad_pkg::CNT_W-1:0] peak_count,
	input logic suspicious
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mode_rate) && $stable(peak_count)
			&& $stable(suspicious) && $stable(active) && $stable(in_window))
		else $error("result beat changed while stalled");

	// inactive beats report no mode and never flag
	a_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> (mode_rate == '0) && !suspicious)
		else $error("inactive beat carries mode or flag");

	// a counted sample leaves at least one count at the peak
	a_counted_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_window |-> peak_count != '0)
		else $error("counted beat with empty peak");

	// activation needs a nonzero peak
	a_active_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && active |-> peak_count != '0)
		else $error("active beat with empty peak");

endmodule

bind flow_mode_anomaly_detector fmad_checker u_fmad_checker (.*);

/* tb/sv/flow_mode_anomaly_detector_test.sv */
`timescale 1ns / 100ps

module flow_mode_anomaly_detector_test;

	localparam int BINS = 1024;
	localparam int BIN_W = $clog2(BINS);
	localparam logic [fmad_pkg::RATE_W-1:0] RATE_MAX = {fmad_pkg::RATE_W{1'b1}};
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int WINDOW_SPAN = BINS * fmad_pkg::BIN_STEP;
	localparam int DRAIN_PAUSE = 16;
	localparam int HOLD_CYCLES = 120;
	localparam int IDLE_PCT = 22;
	localparam int REPORT_CAP = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [fmad_pkg::PADDR_W-1:0] paddr = '0;
	logic [fmad_pkg::PDATA_W-1:0] pwdata = '0;
	logic [fmad_pkg::PDATA_W-1:0] prdata;
	logic pready;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [fmad_pkg::RATE_W-1:0] rate_sample = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic in_window;
	logic active;
	logic [fmad_pkg::RATE_W-1:0] mode_rate;
	logic [fmad_pkg::CNT_W-1:0] peak_count;
	logic suspicious;

	flow_mode_anomaly_detector #(
		.BINS(BINS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rate_sample(rate_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.in_window(in_window),
		.active(active),
		.mode_rate(mode_rate),
		.peak_count(peak_count),
		.suspicious(suspicious)
	);

	// shadow of the block's registers and histogram
	logic [fmad_pkg::RATE_W-1:0] cfg_base = fmad_pkg::BASE_RESET;
	logic [fmad_pkg::CNT_W-1:0] cfg_act = fmad_pkg::ACT_RESET;
	logic [fmad_pkg::TOL_W-1:0] cfg_tol = fmad_pkg::TOL_RESET;
	logic [fmad_pkg::CNT_W-1:0] hist_model [BINS];
	logic [fmad_pkg::CNT_W-1:0] peak_model = '0;
	logic [BIN_W-1:0] mode_bin_model = '0;

	logic [fmad_pkg::RATE_W-1:0] pending_samples [$];
	fmad_pkg::res_t predicted_reports [$];
	int unsigned hot_bins [3];

	int items_queued = 0;
	int results_seen = 0;
	int mismatches = 0;
	int settings_written = 0;
	int seen_window = 0;
	int seen_active = 0;
	int seen_suspicious = 0;
	bit calm = 1'b0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	function automatic logic [fmad_pkg::RATE_W-1:0] mode_of_histogram();
		logic [63:0] sum;
		sum = 64'(cfg_base) + 64'(mode_bin_model) * fmad_pkg::BIN_STEP;
		return (sum > 64'(RATE_MAX)) ? RATE_MAX : sum[fmad_pkg::RATE_W-1:0];
	endfunction

	// histogram update and anomaly decision for one accepted sample
	function automatic void tally_sample(input logic [fmad_pkg::RATE_W-1:0] s);
		fmad_pkg::res_t r;
		int unsigned bin;
		logic [fmad_pkg::RATE_W-1:0] mode;
		logic [63:0] excess;
		logic [63:0] allow;
		r = '0;
		mode = '0;
		if (s > cfg_base) begin
			bin = (32'(s) - 32'(cfg_base)) / fmad_pkg::BIN_STEP;
			if (bin < BINS) begin
				r.in_window = 1'b1;
				if (hist_model[bin] != fmad_pkg::CNT_MAX)
					hist_model[bin] = hist_model[bin] + 1'b1;
				// ties keep the earlier mode
				if (hist_model[bin] > peak_model) begin
					peak_model = hist_model[bin];
					mode_bin_model = bin[BIN_W-1:0];
				end
			end
		end
		r.active = peak_model > cfg_act;
		if (r.active) begin
			mode = mode_of_histogram();
			if (s > mode) begin
				excess = 64'(s - mode) * 64'(fmad_pkg::MILLI);
				allow = 64'(mode) * 64'(cfg_tol);
				r.suspicious = excess > allow;
			end
		end
		r.mode_rate = mode;
		r.peak_count = peak_model;
		predicted_reports.push_back(r);
	endfunction

	function automatic void push_sample(input logic [63:0] v);
		pending_samples.push_back(v[fmad_pkg::RATE_W-1:0]);
		items_queued++;
	endfunction

	function automatic logic [fmad_pkg::RATE_W-1:0] pick_sample();
		logic [63:0] v;
		logic [63:0] m;
		int unsigned roll;
		roll = $urandom_range(99);
		m = 64'(mode_of_histogram());
		if (roll < 45) begin
			v = 64'(cfg_base) + 64'(hot_bins[$urandom_range(2)]) * fmad_pkg::BIN_STEP
				+ $urandom_range(9);
		end else if (roll < 60) begin
			v = 64'(cfg_base) + $urandom_range(WINDOW_SPAN + 5);
		end else if (roll < 75) begin
			// around the tolerance threshold above the mode
			v = m + m * cfg_tol / fmad_pkg::MILLI + $urandom_range(40) - 20;
		end else if (roll < 88) begin
			v = 64'($urandom);
		end else begin
			case ($urandom_range(5))
				0: v = 0;
				1: v = 64'(cfg_base);
				2: v = 64'(cfg_base) + 1;
				3: v = 64'(cfg_base) + WINDOW_SPAN - 1;
				4: v = 64'(cfg_base) + WINDOW_SPAN;
				default: v = 64'(RATE_MAX);
			endcase
		end
		return v[fmad_pkg::RATE_W-1:0];
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < REPORT_CAP)
				$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		int w;
		logic [31:0] data;
		case (idx)
			fmad_pkg::REG_BASE: w = fmad_pkg::RATE_W;
			fmad_pkg::REG_ACT: w = fmad_pkg::CNT_W;
			fmad_pkg::REG_TOL: w = fmad_pkg::TOL_W;
			default: w = 0;
		endcase
		data = value;
		// junk above the register width half the time
		if ($urandom_range(1))
			data = data | ($urandom << w);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			fmad_pkg::REG_BASE: cfg_base = data[fmad_pkg::RATE_W-1:0];
			fmad_pkg::REG_ACT: cfg_act = data[fmad_pkg::CNT_W-1:0];
			fmad_pkg::REG_TOL: cfg_tol = data[fmad_pkg::TOL_W-1:0];
			default: ;
		endcase
		settings_written++;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (results_seen != items_queued);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rate_sample <= '0;
		end else begin
			if (in_valid && !in_stall)
				tally_sample(rate_sample);
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					rate_sample <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		fmad_pkg::res_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_reports.size() == 0) begin
					if (mismatches < REPORT_CAP)
						$display("%0t: result beat expected none actual mode_rate %0d",
							$time, mode_rate);
					mismatches++;
				end else begin
					want = predicted_reports.pop_front();
					check_field("in_window", want.in_window, in_window);
					check_field("active", want.active, active);
					check_field("mode_rate", want.mode_rate, mode_rate);
					check_field("peak_count", want.peak_count, peak_count);
					check_field("suspicious", want.suspicious, suspicious);
				end
				results_seen++;
				seen_window += in_window;
				seen_active += active;
				seen_suspicious += suspicious;
			end
			// one long hold-off so the block fills up and stalls its input
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_seen >= 400 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin
		int pick;
		int unsigned act_pick;
		foreach (hist_model[i])
			hist_model[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// histogram clearing pass after reset
		@(posedge clk);
		while (in_stall)
			@(posedge clk);

		// reset settings: window edges, far out of range
		push_sample(0);
		push_sample(fmad_pkg::BASE_RESET);
		push_sample(fmad_pkg::BASE_RESET - 1);
		push_sample(fmad_pkg::BASE_RESET + 1);
		push_sample(fmad_pkg::BASE_RESET + 9);
		push_sample(fmad_pkg::BASE_RESET + 10);
		push_sample(fmad_pkg::BASE_RESET + 25);
		push_sample(fmad_pkg::BASE_RESET + WINDOW_SPAN - 1);
		push_sample(fmad_pkg::BASE_RESET + WINDOW_SPAN);
		push_sample(fmad_pkg::BASE_RESET + WINDOW_SPAN + 1);
		push_sample(RATE_MAX);
		push_sample(99999999);
		push_sample(1);
		wait_drained();

		// zero base, zero activation, zero tolerance: active at once
		reg_write(fmad_pkg::REG_BASE, 0);
		reg_write(fmad_pkg::REG_ACT, 0);
		reg_write(fmad_pkg::REG_TOL, 0);
		reg_write(REG_SPARE, $urandom);
		push_sample(0);
		push_sample(1);
		push_sample(9);
		push_sample(10);
		push_sample(15);
		push_sample(WINDOW_SPAN - 1);
		push_sample(WINDOW_SPAN);
		push_sample(RATE_MAX);
		push_sample(2);
		push_sample(64'h5555555);
		wait_drained();

		for (int ph = 0; ph < 12; ph++) begin
			pick = $urandom_range(3);
			case (pick)
				0: reg_write(fmad_pkg::REG_BASE, 0);
				1: reg_write(fmad_pkg::REG_BASE, $urandom_range(1000, 200000));
				2: reg_write(fmad_pkg::REG_BASE, $urandom & 32'(RATE_MAX));
				default: reg_write(fmad_pkg::REG_BASE, 32'(RATE_MAX) - $urandom_range(20000));
			endcase
			pick = $urandom_range(4);
			case (pick)
				0: act_pick = 0;
				1: act_pick = (peak_model > 0) ? peak_model - 1 : 0;
				2: act_pick = peak_model + $urandom_range(1, 30);
				3: act_pick = $urandom_range(65535);
				default: act_pick = 65535;
			endcase
			if (act_pick > 65535)
				act_pick = 65535;
			reg_write(fmad_pkg::REG_ACT, act_pick);
			pick = $urandom_range(3);
			case (pick)
				0: reg_write(fmad_pkg::REG_TOL, 0);
				1: reg_write(fmad_pkg::REG_TOL, fmad_pkg::MILLI);
				2: reg_write(fmad_pkg::REG_TOL, 1023);
				default: reg_write(fmad_pkg::REG_TOL, $urandom_range(1023));
			endcase
			if (ph % 4 == 0)
				reg_write(REG_SPARE, $urandom);
			hot_bins[0] = mode_bin_model;
			hot_bins[1] = $urandom_range(BINS - 1);
			hot_bins[2] = $urandom_range(BINS - 1);
			calm = (ph == 4);
			for (int k = 0; k < 144; k++)
				push_sample(pick_sample());
			wait_drained();
		end
		calm = 1'b0;

		// peak equal to the activation count, then the mode bin moves past it
		reg_write(fmad_pkg::REG_ACT, 32'(peak_model));
		hot_bins[0] = mode_bin_model;
		hot_bins[1] = $urandom_range(BINS - 1);
		hot_bins[2] = 0;
		push_sample(0);
		for (int k = 0; k < 40; k++)
			push_sample(pick_sample());
		wait_drained();

		// mode rate past the top of the range
		reg_write(fmad_pkg::REG_ACT, 0);
		reg_write(fmad_pkg::REG_BASE,
			32'(RATE_MAX) - 32'(mode_bin_model) * fmad_pkg::BIN_STEP + 5);
		for (int k = 0; k < 40; k++)
			push_sample(pick_sample());
		push_sample(RATE_MAX);
		wait_drained();
		reg_write(fmad_pkg::REG_BASE, RATE_MAX);
		for (int k = 0; k < 10; k++)
			push_sample(pick_sample());
		push_sample(RATE_MAX);
		wait_drained();

		$display("%0d samples checked over %0d register writes", results_seen,
			settings_written);
		$display("%0d in window, %0d while active, %0d flagged suspicious",
			seen_window, seen_active, seen_suspicious);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/fmad_pkg.sv
sv/fmad_ram.sv
sv/flow_mode_anomaly_detector.sv
sv/fmad_checker.sv
tb/sv/flow_mode_anomaly_detector_test.sv
